>>> rtl/core/sbpc_pkg.sv
// ----------------------------------------------------------------------------
// sbpc_pkg
// Shared types and codes of the sparse bivariate polynomial combiner.
// ----------------------------------------------------------------------------
package sbpc_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int IN_COEF_W = 16;
    localparam int IN_DEG_W  = 8;
    localparam int IDX_W     = 10;
    localparam int STAT_W    = 2;
    localparam int COEF_W    = 42;
    localparam int DEG_W     = 9;
    localparam int CNT_OUT_W = 11;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;
    localparam logic [OP_W-1:0] OP_READ          = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // combine mode
    localparam logic MODE_PRODUCT = 1'b0;
    localparam logic MODE_SUM     = 1'b1;

    // candidate term source
    localparam logic [1:0] CSRC_PROD   = 2'd0;
    localparam logic [1:0] CSRC_FIRST  = 2'd1;
    localparam logic [1:0] CSRC_SECOND = 2'd2;

    // result write data select
    localparam logic [1:0] WSEL_ACCUM = 2'd0;
    localparam logic [1:0] WSEL_CAND  = 2'd1;
    localparam logic [1:0] WSEL_COPY  = 2'd2;

    typedef struct packed {
        logic signed [IN_COEF_W-1:0] coeff;
        logic signed [IN_DEG_W-1:0]  deg_a;
        logic signed [IN_DEG_W-1:0]  deg_z;
    } t_op_term;

    typedef struct packed {
        logic signed [COEF_W-1:0] coeff;
        logic signed [DEG_W-1:0]  deg_a;
        logic signed [DEG_W-1:0]  deg_z;
    } t_res_term;

    typedef struct packed {
        logic                 first_we;
        logic                 second_we;
        logic                 cand_load;
        logic [1:0]           cand_src;
        logic                 res_we;
        logic [1:0]           res_wsel;
        logic                 out_load;
        logic [STAT_W-1:0]    out_status;
        logic                 out_from_mem;
        logic [CNT_OUT_W-1:0] out_count;
    } t_dp_cmd;

    typedef struct packed {
        logic key_match;
        logic coeff_nonzero;
    } t_dp_stat;

endpackage

>>> rtl/core/sbpc_in_if.sv
// ----------------------------------------------------------------------------
// sbpc_in_if
// Input item channel: valid/ready handshake with the term and command fields.
// ----------------------------------------------------------------------------
interface sbpc_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [sbpc_pkg::OP_W-1:0]                operation;
    logic signed [sbpc_pkg::IN_COEF_W-1:0]    term_coeff;
    logic signed [sbpc_pkg::IN_DEG_W-1:0]     term_deg_a;
    logic signed [sbpc_pkg::IN_DEG_W-1:0]     term_deg_z;
    logic [sbpc_pkg::IDX_W-1:0]               read_index;

    modport source (output valid, operation, term_coeff, term_deg_a, term_deg_z,
                    read_index, input ready);
    modport sink   (input valid, operation, term_coeff, term_deg_a, term_deg_z,
                    read_index, output ready);
endinterface

>>> rtl/core/sbpc_out_if.sv
// ----------------------------------------------------------------------------
// sbpc_out_if
// Result item channel: valid/ready handshake with status and term fields.
// ----------------------------------------------------------------------------
interface sbpc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [sbpc_pkg::STAT_W-1:0]           status;
    logic signed [sbpc_pkg::COEF_W-1:0]    out_coeff;
    logic signed [sbpc_pkg::DEG_W-1:0]     out_deg_a;
    logic signed [sbpc_pkg::DEG_W-1:0]     out_deg_z;
    logic [sbpc_pkg::CNT_OUT_W-1:0]        result_count;

    modport source (output valid, status, out_coeff, out_deg_a, out_deg_z,
                    result_count, input ready);
    modport sink   (input valid, status, out_coeff, out_deg_a, out_deg_z,
                    result_count, output ready);
endinterface

>>> rtl/core/sbpc_datapath.sv
// ----------------------------------------------------------------------------
// sbpc_datapath
// Operand stores, result table, product/sum candidate, merge arithmetic and
// the output payload register.
// ----------------------------------------------------------------------------
module sbpc_datapath #(
    parameter int OPERAND_TERMS = 32,
    parameter int RESULT_TERMS  = 1024
) (
    input  logic                                    i_clk,
    input  sbpc_pkg::t_dp_cmd                       i_cmd,
    input  logic [$clog2(OPERAND_TERMS)-1:0]        i_first_addr,
    input  logic [$clog2(OPERAND_TERMS)-1:0]        i_second_addr,
    input  logic [$clog2(RESULT_TERMS)-1:0]         i_res_raddr,
    input  logic [$clog2(RESULT_TERMS)-1:0]         i_res_waddr,
    input  logic signed [sbpc_pkg::IN_COEF_W-1:0]   i_term_coeff,
    input  logic signed [sbpc_pkg::IN_DEG_W-1:0]    i_term_deg_a,
    input  logic signed [sbpc_pkg::IN_DEG_W-1:0]    i_term_deg_z,
    output sbpc_pkg::t_dp_stat                      o_stat,
    output logic [sbpc_pkg::STAT_W-1:0]             o_status,
    output logic signed [sbpc_pkg::COEF_W-1:0]      o_coeff,
    output logic signed [sbpc_pkg::DEG_W-1:0]       o_deg_a,
    output logic signed [sbpc_pkg::DEG_W-1:0]       o_deg_z,
    output logic [sbpc_pkg::CNT_OUT_W-1:0]          o_count
);

    sbpc_pkg::t_op_term  r_first_mem  [OPERAND_TERMS];
    sbpc_pkg::t_op_term  r_second_mem [OPERAND_TERMS];
    sbpc_pkg::t_res_term r_res_mem    [RESULT_TERMS];

    sbpc_pkg::t_op_term  r_first_q;
    sbpc_pkg::t_op_term  r_second_q;
    sbpc_pkg::t_res_term r_res_q;
    sbpc_pkg::t_res_term r_cand;
    sbpc_pkg::t_res_term n_cand;
    sbpc_pkg::t_res_term n_res_wdata;
    sbpc_pkg::t_op_term  w_in_term;

    logic signed [2*sbpc_pkg::IN_COEF_W-1:0] w_prod;

    logic [sbpc_pkg::STAT_W-1:0]        r_status;
    logic signed [sbpc_pkg::COEF_W-1:0] r_coeff;
    logic signed [sbpc_pkg::DEG_W-1:0]  r_deg_a;
    logic signed [sbpc_pkg::DEG_W-1:0]  r_deg_z;
    logic [sbpc_pkg::CNT_OUT_W-1:0]     r_count;

    assign w_in_term.coeff = i_term_coeff;
    assign w_in_term.deg_a = i_term_deg_a;
    assign w_in_term.deg_z = i_term_deg_z;

    // operand stores: one address each, shared by append and fetch
    always_ff @(posedge i_clk) begin
        if (i_cmd.first_we) begin
            r_first_mem[i_first_addr] <= w_in_term;
        end
        if (i_cmd.second_we) begin
            r_second_mem[i_second_addr] <= w_in_term;
        end
        r_first_q  <= r_first_mem[i_first_addr];
        r_second_q <= r_second_mem[i_second_addr];
    end

    // candidate term from one pair or one operand term
    assign w_prod = r_first_q.coeff * r_second_q.coeff;

    always_comb begin
        case (i_cmd.cand_src)
            sbpc_pkg::CSRC_PROD: begin
                n_cand.coeff = sbpc_pkg::COEF_W'(w_prod);
                n_cand.deg_a = sbpc_pkg::DEG_W'(r_first_q.deg_a)
                             + sbpc_pkg::DEG_W'(r_second_q.deg_a);
                n_cand.deg_z = sbpc_pkg::DEG_W'(r_first_q.deg_z)
                             + sbpc_pkg::DEG_W'(r_second_q.deg_z);
            end
            sbpc_pkg::CSRC_FIRST: begin
                n_cand.coeff = sbpc_pkg::COEF_W'(r_first_q.coeff);
                n_cand.deg_a = sbpc_pkg::DEG_W'(r_first_q.deg_a);
                n_cand.deg_z = sbpc_pkg::DEG_W'(r_first_q.deg_z);
            end
            default: begin
                n_cand.coeff = sbpc_pkg::COEF_W'(r_second_q.coeff);
                n_cand.deg_a = sbpc_pkg::DEG_W'(r_second_q.deg_a);
                n_cand.deg_z = sbpc_pkg::DEG_W'(r_second_q.deg_z);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_load) begin
            r_cand <= n_cand;
        end
    end

    // result table write data
    always_comb begin
        case (i_cmd.res_wsel)
            sbpc_pkg::WSEL_ACCUM: begin
                n_res_wdata       = r_cand;
                n_res_wdata.coeff = r_res_q.coeff + r_cand.coeff;
            end
            sbpc_pkg::WSEL_CAND: n_res_wdata = r_cand;
            default:             n_res_wdata = r_res_q;
        endcase
    end

    // result table: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            r_res_mem[i_res_waddr] <= n_res_wdata;
        end
        r_res_q <= r_res_mem[i_res_raddr];
    end

    assign o_stat.key_match     = (r_res_q.deg_a == r_cand.deg_a)
                               && (r_res_q.deg_z == r_cand.deg_z);
    assign o_stat.coeff_nonzero = (r_res_q.coeff != '0);

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_count  <= i_cmd.out_count;
            if (i_cmd.out_from_mem) begin
                r_coeff <= r_res_q.coeff;
                r_deg_a <= r_res_q.deg_a;
                r_deg_z <= r_res_q.deg_z;
            end else begin
                r_coeff <= '0;
                r_deg_a <= '0;
                r_deg_z <= '0;
            end
        end
    end

    assign o_status = r_status;
    assign o_coeff  = r_coeff;
    assign o_deg_a  = r_deg_a;
    assign o_deg_z  = r_deg_z;
    assign o_count  = r_count;

endmodule

>>> rtl/core/sbpc_ctrl.sv
// ----------------------------------------------------------------------------
// sbpc_ctrl
// Sequencer: store counts, pair walk, result table search and compaction,
// handshake and the output valid flag.
// ----------------------------------------------------------------------------
module sbpc_ctrl #(
    parameter int OPERAND_TERMS = 32,
    parameter int RESULT_TERMS  = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [sbpc_pkg::OP_W-1:0]            i_operation,
    input  logic [sbpc_pkg::IDX_W-1:0]           i_read_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  sbpc_pkg::t_dp_stat                   i_stat,
    output sbpc_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(OPERAND_TERMS)-1:0]     o_first_addr,
    output logic [$clog2(OPERAND_TERMS)-1:0]     o_second_addr,
    output logic [$clog2(RESULT_TERMS)-1:0]      o_res_raddr,
    output logic [$clog2(RESULT_TERMS)-1:0]      o_res_waddr
);

    localparam int OW    = $clog2(OPERAND_TERMS);
    localparam int CNT_W = $clog2(OPERAND_TERMS + 1);
    localparam int RW    = $clog2(RESULT_TERMS);
    localparam int SW    = $clog2(RESULT_TERMS + 1);
    localparam int IW    = (SW > sbpc_pkg::IDX_W) ? SW : sbpc_pkg::IDX_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_CAND  = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SCMP  = 4'd4;
    localparam logic [3:0] S_ADV   = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CCHK  = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;

    logic [3:0]       r_state, n_state;
    logic             r_mode;
    logic             r_phase, n_phase;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_fcnt, n_fcnt;
    logic [CNT_W-1:0] r_scnt, n_scnt;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [SW-1:0]    r_size, n_size;
    logic [SW-1:0]    r_k, n_k;
    logic [SW-1:0]    r_w, n_w;
    logic             w_accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // store addresses: append slot while idle, walk position otherwise
    assign o_first_addr  = (r_state == S_IDLE) ? r_fcnt[OW-1:0] : r_i[OW-1:0];
    assign o_second_addr = (r_state == S_IDLE) ? r_scnt[OW-1:0] : r_j[OW-1:0];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fcnt      = r_fcnt;
        n_scnt      = r_scnt;
        n_i         = r_i;
        n_j         = r_j;
        n_size      = r_size;
        n_k         = r_k;
        n_w         = r_w;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.out_count = sbpc_pkg::CNT_OUT_W'(r_size);
        o_res_raddr = r_k[RW-1:0];
        o_res_waddr = r_k[RW-1:0];

        case (r_state)
            S_IDLE: begin
                o_res_raddr = RW'(i_read_index);
                if (w_accept) begin
                    case (i_operation)
                        sbpc_pkg::OP_APPEND_FIRST: begin
                            o_cmd.out_load = 1'b1;
                            n_out_valid    = 1'b1;
                            if (r_fcnt == CNT_W'(OPERAND_TERMS)) begin
                                o_cmd.out_status = sbpc_pkg::ST_FULL;
                            end else begin
                                o_cmd.first_we = 1'b1;
                                n_fcnt = r_fcnt + CNT_W'(1);
                            end
                        end
                        sbpc_pkg::OP_APPEND_SECOND: begin
                            o_cmd.out_load = 1'b1;
                            n_out_valid    = 1'b1;
                            if (r_scnt == CNT_W'(OPERAND_TERMS)) begin
                                o_cmd.out_status = sbpc_pkg::ST_FULL;
                            end else begin
                                o_cmd.second_we = 1'b1;
                                n_scnt = r_scnt + CNT_W'(1);
                            end
                        end
                        sbpc_pkg::OP_COMPUTE: begin
                            n_size  = '0;
                            n_i     = '0;
                            n_j     = '0;
                            n_k     = '0;
                            n_w     = '0;
                            n_phase = 1'b0;
                            if (r_mode == sbpc_pkg::MODE_PRODUCT) begin
                                if (r_fcnt == '0 || r_scnt == '0) begin
                                    n_state = S_CRD;
                                end else begin
                                    n_state = S_FETCH;
                                end
                            end else if (r_fcnt != '0) begin
                                n_state = S_FETCH;
                            end else if (r_scnt != '0) begin
                                n_phase = 1'b1;
                                n_state = S_FETCH;
                            end else begin
                                n_state = S_CRD;
                            end
                        end
                        default: begin
                            if (IW'(i_read_index) >= IW'(r_size)) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = sbpc_pkg::ST_RANGE;
                                n_out_valid      = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end

            // table word at the read index is now registered
            S_RD: begin
                o_cmd.out_load     = 1'b1;
                o_cmd.out_from_mem = 1'b1;
                n_out_valid        = 1'b1;
                n_state            = S_IDLE;
            end

            S_FETCH: begin
                n_state = S_CAND;
            end

            S_CAND: begin
                o_cmd.cand_load = 1'b1;
                if (r_mode == sbpc_pkg::MODE_PRODUCT) begin
                    o_cmd.cand_src = sbpc_pkg::CSRC_PROD;
                end else if (!r_phase) begin
                    o_cmd.cand_src = sbpc_pkg::CSRC_FIRST;
                end else begin
                    o_cmd.cand_src = sbpc_pkg::CSRC_SECOND;
                end
                n_k     = '0;
                n_state = S_SRD;
            end

            // linear search of the table for the candidate key
            S_SRD: begin
                if (r_k == r_size) begin
                    o_res_waddr = r_size[RW-1:0];
                    if (r_size != SW'(RESULT_TERMS)) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_wsel = sbpc_pkg::WSEL_CAND;
                        n_size = r_size + SW'(1);
                    end
                    n_state = S_ADV;
                end else begin
                    n_state = S_SCMP;
                end
            end

            S_SCMP: begin
                if (i_stat.key_match) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_wsel = sbpc_pkg::WSEL_ACCUM;
                    n_state = S_ADV;
                end else begin
                    n_k     = r_k + SW'(1);
                    n_state = S_SRD;
                end
            end

            // step to the next pair or operand term
            S_ADV: begin
                n_state = S_FETCH;
                if (r_mode == sbpc_pkg::MODE_PRODUCT) begin
                    if (r_j + CNT_W'(1) == r_scnt) begin
                        n_j = '0;
                        if (r_i + CNT_W'(1) == r_fcnt) begin
                            n_state = S_CRD;
                        end else begin
                            n_i = r_i + CNT_W'(1);
                        end
                    end else begin
                        n_j = r_j + CNT_W'(1);
                    end
                end else if (!r_phase) begin
                    if (r_i + CNT_W'(1) == r_fcnt) begin
                        n_phase = 1'b1;
                        n_j     = '0;
                        if (r_scnt == '0) begin
                            n_state = S_CRD;
                        end
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                end else begin
                    if (r_j + CNT_W'(1) == r_scnt) begin
                        n_state = S_CRD;
                    end else begin
                        n_j = r_j + CNT_W'(1);
                    end
                end
                if (n_state == S_CRD) begin
                    n_k = '0;
                    n_w = '0;
                end
            end

            // compaction: drop zero terms, keep order
            S_CRD: begin
                if (r_k == r_size) begin
                    n_size           = r_w;
                    n_fcnt           = '0;
                    n_scnt           = '0;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_count  = sbpc_pkg::CNT_OUT_W'(r_w);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_CCHK;
                end
            end

            S_CCHK: begin
                o_res_waddr = r_w[RW-1:0];
                if (i_stat.coeff_nonzero) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_wsel = sbpc_pkg::WSEL_COPY;
                    n_w = r_w + SW'(1);
                end
                n_k     = r_k + SW'(1);
                n_state = S_CRD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= sbpc_pkg::MODE_PRODUCT;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_fcnt      <= '0;
            r_scnt      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_size      <= '0;
            r_k         <= '0;
            r_w         <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_fcnt      <= n_fcnt;
            r_scnt      <= n_scnt;
            r_i         <= n_i;
            r_j         <= n_j;
            r_size      <= n_size;
            r_k         <= n_k;
            r_w         <= n_w;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

endmodule

>>> rtl/core/sparse_bivariate_poly_combine.sv
// ----------------------------------------------------------------------------
// sparse_bivariate_poly_combine
// Product or sum of two sparse polynomials in a and z, with term merging.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_in (valid/ready); each yields one item on o_out.
// Appends store a term in the first or second operand store (status full when
// the store holds OPERAND_TERMS terms). A compute item combines the stores as
// the mode register says (i_cfg_we/i_cfg_data: 0 product, 1 sum), merges
// equal degree pairs, drops zero terms and empties both stores. A read item
// returns the result term at read_index.
// Compute, per pair (product) or per operand term (sum), fetches the
// operand terms, forms the candidate term and searches the result table
// linearly, adding into the entry of equal degrees or, if there is room,
// opening a new one; a compaction pass then copies the nonzero entries
// down in order. A read passes the registered table port to the output.
// One item is in work at a time. A finished result sits in the output
// register and the next item is taken no earlier than the cycle in which that
// result leaves, so a stalled receiver holds the result and blocks new items.
// Reset empties stores and result and sets mode to product; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module sparse_bivariate_poly_combine #(
    parameter int OPERAND_TERMS = 32,
    parameter int RESULT_TERMS  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    sbpc_in_if.sink     i_in,
    sbpc_out_if.source  o_out
);

    sbpc_pkg::t_dp_cmd                w_cmd;
    sbpc_pkg::t_dp_stat               w_stat;
    logic [$clog2(OPERAND_TERMS)-1:0] w_first_addr;
    logic [$clog2(OPERAND_TERMS)-1:0] w_second_addr;
    logic [$clog2(RESULT_TERMS)-1:0]  w_res_raddr;
    logic [$clog2(RESULT_TERMS)-1:0]  w_res_waddr;

    // sequencer
    sbpc_ctrl #(
        .OPERAND_TERMS (OPERAND_TERMS),
        .RESULT_TERMS  (RESULT_TERMS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_operation   (i_in.operation),
        .i_read_index  (i_in.read_index),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd),
        .o_first_addr  (w_first_addr),
        .o_second_addr (w_second_addr),
        .o_res_raddr   (w_res_raddr),
        .o_res_waddr   (w_res_waddr)
    );

    // stores, arithmetic and output payload
    sbpc_datapath #(
        .OPERAND_TERMS (OPERAND_TERMS),
        .RESULT_TERMS  (RESULT_TERMS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_first_addr  (w_first_addr),
        .i_second_addr (w_second_addr),
        .i_res_raddr   (w_res_raddr),
        .i_res_waddr   (w_res_waddr),
        .i_term_coeff  (i_in.term_coeff),
        .i_term_deg_a  (i_in.term_deg_a),
        .i_term_deg_z  (i_in.term_deg_z),
        .o_stat        (w_stat),
        .o_status      (o_out.status),
        .o_coeff       (o_out.out_coeff),
        .o_deg_a       (o_out.out_deg_a),
        .o_deg_z       (o_out.out_deg_z),
        .o_count       (o_out.result_count)
    );

endmodule

>>> bench/tb_sparse_bivariate_poly_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_bivariate_poly_combine
// Self-checking bench for the sparse polynomial combiner. A directed table
// covers field extremes, empty operand stores, zero-term removal and
// out-of-range reads. Random phases of appends, computes and reads follow
// under both modes. Every result item is checked against a local predictor or
// a typed-in status; random idling on both sides, one long receiver stall.
// ----------------------------------------------------------------------------
module tb_sparse_bivariate_poly_combine;

    localparam int N_OPER       = 32;
    localparam int N_RES        = 1024;
    localparam int RANDOM_ITEMS = 260;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [sbpc_pkg::STAT_W-1:0]        status;
        logic signed [sbpc_pkg::COEF_W-1:0] coeff;
        logic signed [sbpc_pkg::DEG_W-1:0]  deg_a;
        logic signed [sbpc_pkg::DEG_W-1:0]  deg_z;
        logic [sbpc_pkg::CNT_OUT_W-1:0]     count;
    } t_reply;

    // one row of the directed table; has_exp marks typed-in results
    typedef struct {
        logic                                  set_cfg;
        logic                                  mode;
        logic [sbpc_pkg::OP_W-1:0]             op;
        logic signed [sbpc_pkg::IN_COEF_W-1:0] coeff;
        logic signed [sbpc_pkg::IN_DEG_W-1:0]  deg_a;
        logic signed [sbpc_pkg::IN_DEG_W-1:0]  deg_z;
        logic [sbpc_pkg::IDX_W-1:0]            idx;
        logic                                  has_exp;
        logic [sbpc_pkg::STAT_W-1:0]           exp_status;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    sbpc_in_if  in_if ();
    sbpc_out_if out_if ();

    sparse_bivariate_poly_combine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state
    sbpc_pkg::t_op_term  pm_first [N_OPER];
    sbpc_pkg::t_op_term  pm_second[N_OPER];
    sbpc_pkg::t_res_term pm_res   [N_RES];
    int        pm_first_n;
    int        pm_second_n;
    int        pm_res_n;
    logic      pm_mode;

    t_reply pending_replies[$];
    int     errors;
    int     items_sent;
    int     n_computes;
    int     n_reads;
    int     n_full;
    int     n_range;
    longint cycles = 0;
    logic   no_idle;
    logic   stall_done;
    int     stall_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[sparse_bivariate_poly_combine] ERROR");
            $finish;
        end
    end

    // merge one candidate term into the result table
    function automatic void merge_term(logic signed [sbpc_pkg::COEF_W-1:0] c,
                                       logic signed [sbpc_pkg::DEG_W-1:0] a,
                                       logic signed [sbpc_pkg::DEG_W-1:0] z);
        for (int k = 0; k < pm_res_n; k++) begin
            if (pm_res[k].deg_a == a && pm_res[k].deg_z == z) begin
                pm_res[k].coeff = pm_res[k].coeff + c;
                return;
            end
        end
        if (pm_res_n < N_RES) begin
            pm_res[pm_res_n].coeff = c;
            pm_res[pm_res_n].deg_a = a;
            pm_res[pm_res_n].deg_z = z;
            pm_res_n++;
        end
    endfunction

    // product or sum, then drop zero terms and empty the stores
    function automatic void combine_stores();
        int kept;
        logic signed [sbpc_pkg::COEF_W-1:0] c;
        logic signed [sbpc_pkg::DEG_W-1:0]  a;
        logic signed [sbpc_pkg::DEG_W-1:0]  z;
        kept = 0;
        pm_res_n = 0;
        if (pm_mode == sbpc_pkg::MODE_PRODUCT) begin
            for (int i = 0; i < pm_first_n; i++)
                for (int j = 0; j < pm_second_n; j++) begin
                    c = pm_first[i].coeff * pm_second[j].coeff;
                    a = pm_first[i].deg_a + pm_second[j].deg_a;
                    z = pm_first[i].deg_z + pm_second[j].deg_z;
                    merge_term(c, a, z);
                end
        end else begin
            for (int i = 0; i < pm_first_n; i++)
                merge_term(pm_first[i].coeff, pm_first[i].deg_a, pm_first[i].deg_z);
            for (int j = 0; j < pm_second_n; j++)
                merge_term(pm_second[j].coeff, pm_second[j].deg_a, pm_second[j].deg_z);
        end
        for (int i = 0; i < pm_res_n; i++) begin
            if (pm_res[i].coeff != 0) begin
                pm_res[kept] = pm_res[i];
                kept++;
            end
        end
        pm_res_n = kept;
        pm_first_n = 0;
        pm_second_n = 0;
    endfunction

    // expected result of one accepted item, updating predictor state
    function automatic t_reply predict_reply(logic [sbpc_pkg::OP_W-1:0] op,
                                             logic signed [sbpc_pkg::IN_COEF_W-1:0] c,
                                             logic signed [sbpc_pkg::IN_DEG_W-1:0] a,
                                             logic signed [sbpc_pkg::IN_DEG_W-1:0] z,
                                             logic [sbpc_pkg::IDX_W-1:0] idx);
        t_reply r;
        r = '{sbpc_pkg::ST_OK, '0, '0, '0, '0};
        case (op)
            sbpc_pkg::OP_APPEND_FIRST: begin
                if (pm_first_n >= N_OPER) r.status = sbpc_pkg::ST_FULL;
                else begin
                    pm_first[pm_first_n] = '{c, a, z};
                    pm_first_n++;
                end
            end
            sbpc_pkg::OP_APPEND_SECOND: begin
                if (pm_second_n >= N_OPER) r.status = sbpc_pkg::ST_FULL;
                else begin
                    pm_second[pm_second_n] = '{c, a, z};
                    pm_second_n++;
                end
            end
            sbpc_pkg::OP_COMPUTE: combine_stores();
            default: begin
                if (idx >= pm_res_n) r.status = sbpc_pkg::ST_RANGE;
                else begin
                    r.coeff = pm_res[idx].coeff;
                    r.deg_a = pm_res[idx].deg_a;
                    r.deg_z = pm_res[idx].deg_z;
                end
            end
        endcase
        r.count = sbpc_pkg::CNT_OUT_W'(pm_res_n);
        return r;
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item and wait for it to be taken; called at a falling edge
    task automatic send_item(logic [sbpc_pkg::OP_W-1:0] op,
                             logic signed [sbpc_pkg::IN_COEF_W-1:0] c,
                             logic signed [sbpc_pkg::IN_DEG_W-1:0] a,
                             logic signed [sbpc_pkg::IN_DEG_W-1:0] z,
                             logic [sbpc_pkg::IDX_W-1:0] idx,
                             logic has_exp, logic [sbpc_pkg::STAT_W-1:0] exp_status);
        int gap;
        t_reply r;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.operation  = op;
        in_if.term_coeff = c;
        in_if.term_deg_a = a;
        in_if.term_deg_z = z;
        in_if.read_index = idx;
        in_if.valid      = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        r = predict_reply(op, c, a, z, idx);
        if (has_exp) r = '{exp_status, '0, '0, '0, '0};
        pending_replies.push_back(r);
        items_sent++;
        if (op == sbpc_pkg::OP_COMPUTE) n_computes++;
        if (op == sbpc_pkg::OP_READ) n_reads++;
        if (r.status == sbpc_pkg::ST_FULL) n_full++;
        if (r.status == sbpc_pkg::ST_RANGE) n_range++;
        @(negedge i_clk);
    endtask

    // drain, then write the mode register while the block is idle
    task automatic write_mode(logic m);
        in_if.valid = 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        pm_mode    = m;
    endtask

    // receiver readiness, with one long hold-off once traffic is flowing
    initial begin
        stall_done = 1'b0;
        stall_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!stall_done && items_sent >= 120) begin
                stall_done = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready = 1'b0;
            end else if (no_idle) begin
                out_if.ready = 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                out_if.ready = 1'b0;
                stall_left = $urandom_range(10, 40);
            end else begin
                out_if.ready = ($urandom_range(0, 9) < 7);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_replies.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = pending_replies.pop_front();
                if (out_if.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, out_if.status);
                    errors++;
                end
                if (out_if.out_coeff !== e.coeff) begin
                    $error("out_coeff: expected %0d actual %0d", e.coeff, out_if.out_coeff);
                    errors++;
                end
                if (out_if.out_deg_a !== e.deg_a) begin
                    $error("out_deg_a: expected %0d actual %0d", e.deg_a, out_if.out_deg_a);
                    errors++;
                end
                if (out_if.out_deg_z !== e.deg_z) begin
                    $error("out_deg_z: expected %0d actual %0d", e.deg_z, out_if.out_deg_z);
                    errors++;
                end
                if (out_if.result_count !== e.count) begin
                    $error("result_count: expected %0d actual %0d", e.count,
                           out_if.result_count);
                    errors++;
                end
            end
        end
    end

    // directed table: reset state, extremes, zero removal, empty operands
    t_row dir_rows[] = '{
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b1, sbpc_pkg::ST_RANGE},
        '{1'b0, 1'b0, sbpc_pkg::OP_COMPUTE,       16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b1, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_FIRST,  16'sd32767,  8'sd127,  8'sd127,
          10'd1023, 1'b1, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_FIRST,  -16'sd32768, -8'sd128, -8'sd128,
          10'd0,    1'b1, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_SECOND, -16'sd32768, -8'sd128, -8'sd128,
          10'd0,    1'b1, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_SECOND, 16'sd32767,  8'sd127,  8'sd127,
          10'd0,    1'b1, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_SECOND, 16'sd1,      8'sd0,    8'sd0,
          10'd0,    1'b1, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd1023, 1'b1, sbpc_pkg::ST_RANGE},
        '{1'b0, 1'b0, sbpc_pkg::OP_COMPUTE,       16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd1,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd2,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd3,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd4,    1'b0, sbpc_pkg::ST_OK},
        '{1'b1, 1'b1, sbpc_pkg::OP_APPEND_FIRST,  16'sd5,      8'sd1,    8'sd1,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_SECOND, -16'sd5,     8'sd1,    8'sd1,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_FIRST,  16'sd7,      -8'sd1,   8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_SECOND, 16'sd3,      -8'sd1,   8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_COMPUTE,       16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd1,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_APPEND_SECOND, 16'sd9,      8'sd3,    -8'sd3,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_COMPUTE,       16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd0,    1'b0, sbpc_pkg::ST_OK},
        '{1'b0, 1'b0, sbpc_pkg::OP_READ,          16'sd0,      8'sd0,    8'sd0,
          10'd682,  1'b0, sbpc_pkg::ST_OK}
    };

    // one random phase: load operands, compute, read back
    task automatic run_phase();
        int  n1;
        int  n2;
        int  nr;
        int  which;
        int  spread;
        logic overfill;
        logic signed [sbpc_pkg::IN_COEF_W-1:0] c;
        logic signed [sbpc_pkg::IN_DEG_W-1:0]  a;
        logic signed [sbpc_pkg::IN_DEG_W-1:0]  z;
        logic signed [sbpc_pkg::IN_COEF_W-1:0] rc;
        logic signed [sbpc_pkg::IN_DEG_W-1:0]  ra;
        logic signed [sbpc_pkg::IN_DEG_W-1:0]  rz;
        logic [sbpc_pkg::IDX_W-1:0]            ri;
        write_mode(1'($urandom_range(0, 1)));
        no_idle  = ($urandom_range(0, 4) == 0);
        overfill = ($urandom_range(0, 9) == 0);
        n1 = overfill ? 34 : $urandom_range(0, 5);
        n2 = overfill ? $urandom_range(0, 1) : $urandom_range(0, 5);
        spread = ($urandom_range(0, 2) == 0) ? 127 : 2;
        rc = sbpc_pkg::IN_COEF_W'($urandom);
        ra = sbpc_pkg::IN_DEG_W'($urandom);
        rz = sbpc_pkg::IN_DEG_W'($urandom);
        ri = sbpc_pkg::IDX_W'($urandom);
        if ($urandom_range(0, 5) == 0)
            send_item(sbpc_pkg::OP_READ, rc, ra, rz, ri, 1'b0, sbpc_pkg::ST_OK);
        while (n1 + n2 > 0) begin
            which = (n2 == 0) ? 0 : (n1 == 0) ? 1 : $urandom_range(0, 1);
            c = ($urandom_range(0, 3) == 0) ? sbpc_pkg::IN_COEF_W'($urandom)
                : sbpc_pkg::IN_COEF_W'($urandom_range(0, 8) - 4);
            a = sbpc_pkg::IN_DEG_W'($urandom_range(0, 2 * spread) - spread);
            z = sbpc_pkg::IN_DEG_W'($urandom_range(0, 2 * spread) - spread);
            if (spread == 127 && $urandom_range(0, 3) == 0) begin
                a = sbpc_pkg::IN_DEG_W'($urandom);
                z = sbpc_pkg::IN_DEG_W'($urandom);
            end
            ri = sbpc_pkg::IDX_W'($urandom);
            if (which == 0) begin
                send_item(sbpc_pkg::OP_APPEND_FIRST, c, a, z, ri, 1'b0, sbpc_pkg::ST_OK);
                n1--;
                // in sum mode, a cancelling partner exercises zero removal
                if (pm_mode == sbpc_pkg::MODE_SUM && n2 > 0 && $urandom_range(0, 2) == 0) begin
                    send_item(sbpc_pkg::OP_APPEND_SECOND,
                              (c == -16'sd32768) ? 16'sd1 : -c, a, z,
                              ri, 1'b0, sbpc_pkg::ST_OK);
                    n2--;
                end
            end else begin
                send_item(sbpc_pkg::OP_APPEND_SECOND, c, a, z, ri, 1'b0, sbpc_pkg::ST_OK);
                n2--;
            end
        end
        rc = sbpc_pkg::IN_COEF_W'($urandom);
        ra = sbpc_pkg::IN_DEG_W'($urandom);
        rz = sbpc_pkg::IN_DEG_W'($urandom);
        ri = sbpc_pkg::IDX_W'($urandom);
        send_item(sbpc_pkg::OP_COMPUTE, rc, ra, rz, ri, 1'b0, sbpc_pkg::ST_OK);
        nr = $urandom_range(2, 6);
        repeat (nr) begin
            rc = sbpc_pkg::IN_COEF_W'($urandom);
            ra = sbpc_pkg::IN_DEG_W'($urandom);
            rz = sbpc_pkg::IN_DEG_W'($urandom);
            if ($urandom_range(0, 9) < 8)
                ri = sbpc_pkg::IDX_W'($urandom_range(0, pm_res_n));
            else
                ri = sbpc_pkg::IDX_W'($urandom);
            send_item(sbpc_pkg::OP_READ, rc, ra, rz, ri, 1'b0, sbpc_pkg::ST_OK);
        end
    endtask

    // main stimulus
    initial begin
        int dir_count;
        int settle;
        errors      = 0;
        items_sent  = 0;
        n_computes  = 0;
        n_reads     = 0;
        n_full      = 0;
        n_range     = 0;
        no_idle     = 1'b0;
        pm_first_n  = 0;
        pm_second_n = 0;
        pm_res_n    = 0;
        pm_mode     = sbpc_pkg::MODE_PRODUCT;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 1'b0;
        in_if.valid      = 1'b0;
        in_if.operation  = sbpc_pkg::OP_READ;
        in_if.term_coeff = '0;
        in_if.term_deg_a = '0;
        in_if.term_deg_z = '0;
        in_if.read_index = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_cfg) write_mode(dir_rows[k].mode);
            send_item(dir_rows[k].op, dir_rows[k].coeff, dir_rows[k].deg_a,
                      dir_rows[k].deg_z, dir_rows[k].idx, dir_rows[k].has_exp,
                      dir_rows[k].exp_status);
        end
        dir_count = items_sent;

        while (items_sent < dir_count + RANDOM_ITEMS) run_phase();
        write_mode(sbpc_pkg::MODE_PRODUCT);

        // drain and let the block settle
        in_if.valid = 1'b0;
        settle = 0;
        while (pending_replies.size() != 0 && settle < 100000) begin
            @(negedge i_clk);
            settle++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d expected results never arrived", pending_replies.size());
            errors++;
        end

        $display("covered %0d items: %0d computes, %0d reads, %0d full-store drops,",
                 items_sent, n_computes, n_reads, n_full);
        $display("%0d out-of-range reads, both combine modes, one long output stall",
                 n_range);
        if (errors == 0)
            $display("[sparse_bivariate_poly_combine] OK");
        else
            $display("[sparse_bivariate_poly_combine] ERROR");
        $finish;
    end

endmodule

>>> sparse_bivariate_poly_combine.f
rtl/core/sbpc_pkg.sv
rtl/core/sbpc_in_if.sv
rtl/core/sbpc_out_if.sv
rtl/core/sbpc_datapath.sv
rtl/core/sbpc_ctrl.sv
rtl/core/sparse_bivariate_poly_combine.sv
bench/tb_sparse_bivariate_poly_combine.sv
